@@ rtl/smpq_pkg.sv @@
// Shared types and codes for the sorted max-priority queue.
`default_nettype none
package smpq_pkg;

   localparam int ValueWidth = 32;
   localparam int CountOutWidth = 5;

   typedef enum logic {
      CMD_ENQUEUE = 1'b0,
      CMD_DEQUEUE = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ENQ,
      ST_HEAD,
      ST_DEQ,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [ValueWidth-1:0] result_value;
      status_type                   status;
      logic                         is_empty;
      logic [CountOutWidth-1:0]     entry_count;
   } rsp_type;

endpackage
`default_nettype wire

@@ rtl/smpq_out_slot.sv @@
// Output register holding one finished result until the receiver takes it.
`default_nettype none
module smpq_out_slot (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  wire smpq_pkg::rsp_type load_data,
   output logic                  can_load,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output smpq_pkg::rsp_type     rsp_data
);
   import smpq_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // The slot frees up in the same cycle its item is taken.
   assign can_load = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
`default_nettype wire

@@ rtl/sorted_max_priority_queue.sv @@
// Top level of the sorted max-priority queue.
//
// A bounded max-priority queue of signed 32-bit values held in descending
// order in one synchronous RAM (one write and one registered read a cycle).
// Request channel (req_valid/req_stall): req_command 0 enqueues req_value,
// 1 removes and returns the largest value. Equal values leave in arrival
// order. Each item yields exactly one result on the response channel
// (rsp_valid/rsp_stall): the removed value (zero otherwise), a status
// (ok, dequeue from empty, enqueue into full dropped), the empty flag and
// the count after the item; the count port carries its low five bits.
// One item is worked on at a time; req_stall is high while it is in work.
// The enqueue insertion scan walks from the tail, one RAM read and one
// write per cycle, moving each smaller entry one place back until it
// meets an entry not smaller than the value; a value that goes to the
// front then passes the head state, which is also how a value enters an
// empty queue. Dequeue returns the front entry while the RAM shifts every
// remaining entry forward by one. Full and empty cases skip the RAM.
// A finished result waits in the output register while the receiver
// stalls; the next item can be accepted meanwhile, and its result is held
// back until the register frees. Reset empties the queue at once; no
// clearing pass runs.
`default_nettype none
module sorted_max_priority_queue #(
   parameter int CAPACITY = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_command,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_result_value,
   output logic [1:0]              rsp_status,
   output logic                    rsp_is_empty,
   output logic [4:0]              rsp_entry_count
);
   import smpq_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   state_type                    state_ff, state_in;
   logic signed [ValueWidth-1:0] word_ff, word_in;
   logic [AW-1:0]                idx_ff, idx_in;
   logic [CW-1:0]                count_ff, count_in;
   logic signed [ValueWidth-1:0] res_value_ff, res_value_in;
   status_type                   res_status_ff, res_status_in;

   logic signed [ValueWidth-1:0] mem [CAPACITY];
   logic signed [ValueWidth-1:0] rd_data_ff;
   logic [AW-1:0]                rd_addr;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic signed [ValueWidth-1:0] wr_data;

   logic    can_load;
   logic    load;
   rsp_type load_data;
   rsp_type rsp_data;

   // Writes land at idx+1 (enqueue) or idx-1 (dequeue) while the read runs
   // the other way, so a read that the scan uses never meets a write to the same entry.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = word_ff;
      load          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               word_in       = req_value;
               res_value_in  = '0;
               res_status_in = STATUS_OK;
               if (req_command == CMD_DEQUEUE) begin
                  if (count_ff == '0) begin
                     res_status_in = STATUS_EMPTY;
                     state_in      = ST_DONE;
                  end else begin
                     rd_addr  = '0;
                     idx_in   = '0;
                     state_in = ST_DEQ;
                  end
               end else begin
                  if (count_ff == CW'(CAPACITY)) begin
                     res_status_in = STATUS_FULL;
                     state_in      = ST_DONE;
                  end else if (count_ff == '0) begin
                     state_in = ST_HEAD;
                  end else begin
                     // Scan from the tail towards the front.
                     rd_addr  = AW'(count_ff - CW'(1));
                     idx_in   = AW'(count_ff - CW'(1));
                     state_in = ST_ENQ;
                  end
               end
            end
         end
         ST_ENQ: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff + AW'(1);
            if (word_ff > rd_data_ff) begin
               // Move the smaller entry one place back and keep scanning.
               wr_data = rd_data_ff;
               if (idx_ff == '0) begin
                  state_in = ST_HEAD;
               end else begin
                  idx_in  = idx_ff - AW'(1);
                  rd_addr = idx_ff - AW'(1);
               end
            end else begin
               wr_data  = word_ff;
               count_in = count_ff + CW'(1);
               state_in = ST_DONE;
            end
         end
         ST_HEAD: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = word_ff;
            count_in = count_ff + CW'(1);
            state_in = ST_DONE;
         end
         ST_DEQ: begin
            if (idx_ff == '0) begin
               res_value_in = rd_data_ff;
            end else begin
               wr_en   = 1'b1;
               wr_addr = idx_ff - AW'(1);
               wr_data = rd_data_ff;
            end
            if (CW'(idx_ff) + CW'(1) == count_ff) begin
               count_in = count_ff - CW'(1);
               state_in = ST_DONE;
            end else begin
               idx_in  = idx_ff + AW'(1);
               rd_addr = idx_ff + AW'(1);
            end
         end
         ST_DONE: begin
            if (can_load) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff       <= word_in;
      idx_ff        <= idx_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
   end

   assign load_data.result_value = res_value_ff;
   assign load_data.status       = res_status_ff;
   assign load_data.is_empty     = (count_ff == '0);
   assign load_data.entry_count  = CountOutWidth'(count_ff);

   smpq_out_slot u_out_slot (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .load_data (load_data),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_result_value = rsp_data.result_value;
   assign rsp_status       = rsp_data.status;
   assign rsp_is_empty     = rsp_data.is_empty;
   assign rsp_entry_count  = rsp_data.entry_count;

endmodule
`default_nettype wire

@@ rtl/smpq_checker.sv @@
// Port-level checks for the sorted max-priority queue, bound to the top level.
`default_nettype none
module smpq_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic signed [31:0] rsp_result_value,
   input wire logic [1:0]         rsp_status,
   input wire logic               rsp_is_empty,
   input wire logic [4:0]         rsp_entry_count
);
   import smpq_pkg::*;

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_value)
         && $stable(rsp_status) && $stable(rsp_entry_count))
      else $error("stalled result changed");

   // One item at a time: an accepted item blocks the next in the cycle after.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while previous item in work");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_empty_deq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_is_empty
         && rsp_result_value == 32'sd0)
      else $error("dequeue from empty reported inconsistently");

   a_full_enq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> !rsp_is_empty
         && rsp_result_value == 32'sd0)
      else $error("dropped enqueue reported inconsistently");

endmodule

bind sorted_max_priority_queue smpq_checker u_smpq_checker (.*);
`default_nettype wire

@@ bench/sorted_max_priority_queue_tb.sv @@
// Self-checking bench for the sorted max-priority queue: directed and random items.
module sorted_max_priority_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import smpq_pkg::*;

   localparam int Capacity = 16;
   localparam int RandomItems = 850;
   localparam int SettleCycles = 40;
   localparam int QuietFirst = 300;
   localparam int QuietLast = 450;
   localparam int IdlePercent = 36;

   typedef enum int {
      MIX_EVEN,
      MIX_FILL,
      MIX_DRAIN
   } mix_type;

   // Tracks the stored values in descending order and the results still owed.
   class sorted_queue_tracker;
      int capacity;
      int failures;
      logic signed [ValueWidth-1:0] held_values[$];
      rsp_type due_responses[$];

      function new(int capacity);
         this.capacity = capacity;
         failures = 0;
      endfunction

      function void note_command(command_type cmd, logic signed [ValueWidth-1:0] value);
         rsp_type due;
         int pos;
         due = '0;
         due.status = STATUS_OK;
         if (cmd == CMD_DEQUEUE) begin
            if (held_values.size() == 0) begin
               due.status = STATUS_EMPTY;
            end else begin
               due.result_value = held_values.pop_front();
            end
         end else if (held_values.size() >= capacity) begin
            due.status = STATUS_FULL;
         end else begin
            // equal values keep arrival order: go behind every stored value >= this one
            pos = 0;
            while (pos < held_values.size() && value <= held_values[pos]) pos++;
            held_values.insert(pos, value);
         end
         due.is_empty = (held_values.size() == 0);
         due.entry_count = CountOutWidth'(held_values.size());
         due_responses.push_back(due);
      endfunction

      function void check_response(logic signed [ValueWidth-1:0] value, logic [1:0] status,
                                   logic empty, logic [CountOutWidth-1:0] count);
         rsp_type due;
         if (due_responses.size() == 0) begin
            $error("result with no item outstanding: value %0d status %0d count %0d",
                   value, status, count);
            failures++;
            return;
         end
         due = due_responses.pop_front();
         if (value !== due.result_value) begin
            $error("result_value: expected %0d, got %0d", due.result_value, value);
            failures++;
         end
         if (status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, status);
            failures++;
         end
         if (empty !== due.is_empty) begin
            $error("is_empty: expected %0d, got %0d", due.is_empty, empty);
            failures++;
         end
         if (count !== due.entry_count) begin
            $error("entry_count: expected %0d, got %0d", due.entry_count, count);
            failures++;
         end
      endfunction

      function int outstanding();
         return due_responses.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_command = 1'b0;
   logic signed [31:0] req_value = '0;
   logic rsp_stall = 1'b0;
   logic req_stall;
   logic rsp_valid;
   logic signed [31:0] rsp_result_value;
   logic [1:0] rsp_status;
   logic rsp_is_empty;
   logic [4:0] rsp_entry_count;

   int req_idle_pct = IdlePercent;
   int rsp_idle_pct = IdlePercent;
   sorted_queue_tracker tracker;

   sorted_max_priority_queue #(
      .CAPACITY(Capacity)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_value(rsp_result_value),
      .rsp_status(rsp_status),
      .rsp_is_empty(rsp_is_empty),
      .rsp_entry_count(rsp_entry_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("FAIL sorted_max_priority_queue");
      $finish;
   end

   // Receiver: check each accepted result, then pick the stall for the next edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.check_response(rsp_result_value, rsp_status, rsp_is_empty, rsp_entry_count);
      end
      rsp_stall <= (rsp_idle_pct != 0) && ($urandom_range(99) < rsp_idle_pct);
   end

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(9))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $urandom_range(1) ? 32'sd0 : -32'sd1;
         3, 4, 5: return $signed(32'($urandom_range(8))) - 32'sd4;
         default: return $urandom();
      endcase
   endfunction

   function automatic command_type pick_command(mix_type mix);
      int enqueue_pct;
      case (mix)
         MIX_FILL: enqueue_pct = 85;
         MIX_DRAIN: enqueue_pct = 15;
         default: enqueue_pct = 50;
      endcase
      return ($urandom_range(99) < enqueue_pct) ? CMD_ENQUEUE : CMD_DEQUEUE;
   endfunction

   task automatic send_item(input command_type cmd, input logic signed [31:0] value);
      while (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         req_value <= $urandom();
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_value <= value;
      do begin
         @(posedge clock);
      end while (req_stall);
      tracker.note_command(cmd, value);
   endtask

   // Hold the sender until every owed result has been taken.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (tracker.outstanding() != 0);
   endtask

   initial begin
      mix_type mix;
      int mix_left;
      tracker = new(Capacity);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_item(CMD_DEQUEUE, $urandom());
      send_item(CMD_ENQUEUE, 32'sh7fffffff);
      send_item(CMD_ENQUEUE, 32'sh80000000);
      send_item(CMD_ENQUEUE, 32'sd0);
      send_item(CMD_ENQUEUE, -32'sd1);
      send_item(CMD_ENQUEUE, 32'sd1);
      send_item(CMD_ENQUEUE, 32'sd0);
      send_item(CMD_ENQUEUE, 32'sh7fffffff);
      send_item(CMD_ENQUEUE, 32'sh80000000);
      repeat (Capacity - 8) send_item(CMD_ENQUEUE, pick_value());
      // store is full: even the largest value must be dropped
      send_item(CMD_ENQUEUE, 32'sh7fffffff);
      repeat (3) send_item(CMD_DEQUEUE, $urandom());
      wait_drained();

      mix = MIX_EVEN;
      mix_left = 0;
      for (int i = 0; i < RandomItems; i++) begin
         if (mix_left == 0) begin
            mix = mix_type'($urandom_range(2));
            mix_left = $urandom_range(60, 20);
            if ($urandom_range(3) == 0) wait_drained();
         end
         mix_left--;
         req_idle_pct = (i >= QuietFirst && i < QuietLast) ? 0 : IdlePercent;
         rsp_idle_pct = req_idle_pct;
         send_item(pick_command(mix), pick_value());
      end
      wait_drained();
      repeat (SettleCycles) @(posedge clock);

      if (tracker.failures == 0 && tracker.outstanding() == 0) begin
         $display("PASS sorted_max_priority_queue");
      end else begin
         $display("FAIL sorted_max_priority_queue");
      end
      $finish;
   end

endmodule
